[rtl/core/rwsm_pkg.sv]
// ----------------------------------------------------------------------------
// rwsm_pkg
// shared types and codes for the rolling window sum and mean unit
// ----------------------------------------------------------------------------
package rwsm_pkg;

    localparam int SAMPLE_W  = 32;   // Q16.16 sample width
    localparam int LEN_W     = 11;   // window length and window counters
    localparam int RES_W     = 42;   // result value width
    localparam int CFG_W     = 32;   // config data, widest register
    localparam int CFG_IDX_W = 2;    // config register index

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGGREGATE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MISSING   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE     = 2'd3;

    // sample classes
    localparam logic [1:0] SC_FINITE  = 2'd0;
    localparam logic [1:0] SC_MISSING = 2'd1;
    localparam logic [1:0] SC_PINF    = 2'd2;
    localparam logic [1:0] SC_NINF    = 2'd3;

    // result classes
    localparam logic [2:0] RC_FINITE = 3'd0;
    localparam logic [2:0] RC_FILL   = 3'd1;
    localparam logic [2:0] RC_NA     = 3'd2;
    localparam logic [2:0] RC_NAN    = 3'd3;
    localparam logic [2:0] RC_PINF   = 3'd4;
    localparam logic [2:0] RC_NINF   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_CLS,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [1:0]                 sample_class;
        logic                       series_start;
    } t_in_beat;

    typedef struct packed {
        logic signed [RES_W-1:0] result_value;
        logic [2:0]              result_class;
    } t_out_beat;

endpackage

[rtl/core/rwsm_div.sv]
// ----------------------------------------------------------------------------
// rwsm_div
// radix-2 restoring divider, unsigned, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rwsm_div #(
    parameter int MAG_W = 42,
    parameter int DIV_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(MAG_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;

    logic [DIV_W:0]   trial;
    logic             fits;
    logic [DIV_W:0]   diff;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[MAG_W-1]};
        fits  = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[MAG_W-2:0], fits};
            r_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/core/rolling_window_sum_mean_unit.sv]
// ----------------------------------------------------------------------------
// rolling_window_sum_mean_unit
// sliding window sum and mean over classed Q16.16 samples
// ----------------------------------------------------------------------------
// One input beat gives one output beat. The window contents sit in a single
// synchronous ring memory of MAX_WINDOW entries; the running sum and the
// missing / +inf / -inf counts live in registers and are updated by a
// read-modify-write of the ring entry that leaves the window. Items are worked
// one at a time: accept with ring read, update, classify, output load; a
// finite mean runs the bit-serial divider between classify and output load,
// where SUM_W, the running sum width, sets the quotient bits it works out.
// The output register frees the input side, so a new beat is taken while a
// result still waits for the consumer. The ring needs no clearing after
// reset: an entry's old contents are used only once it has been written.
// ----------------------------------------------------------------------------
module rolling_window_sum_mean_unit #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rwsm_pkg::t_in_beat                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output rwsm_pkg::t_out_beat                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [rwsm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rwsm_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int SAMPLE_W = rwsm_pkg::SAMPLE_W;
    localparam int LEN_W    = rwsm_pkg::LEN_W;
    localparam int RES_W    = rwsm_pkg::RES_W;
    // longest window the length register can express
    localparam int LEN_CAP  = (MAX_WINDOW > 2047) ? 2047 : MAX_WINDOW;
    localparam int PTR_W    = $clog2(MAX_WINDOW);
    localparam int CMP_W    = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;
    // exact sum of LEN_CAP full-scale samples
    localparam int SUM_W    = SAMPLE_W + $clog2(LEN_CAP);
    localparam int EXT_W    = (SUM_W > RES_W) ? SUM_W : RES_W;
    localparam int ENT_W    = SAMPLE_W + 2;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    rwsm_pkg::t_state r_state, n_state;

    logic in_acc;
    logic out_free;
    logic upd_en;
    logic cls_en;
    logic div_start;
    logic out_load;
    logic need_div;
    logic div_done;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]          r_wlen;
    logic                      r_agg;
    logic                      r_skip;
    logic signed [31:0]        r_fill;
    logic                      wlen_wr;

    // ------------------------------------------------------------------
    // window state
    // ------------------------------------------------------------------
    logic [PTR_W-1:0]          r_ptr;
    logic signed [SUM_W-1:0]   r_sum;
    logic [LEN_W-1:0]          r_mis;
    logic [LEN_W-1:0]          r_pinf;
    logic [LEN_W-1:0]          r_ninf;
    logic [LEN_W-1:0]          r_seen;

    logic [ENT_W-1:0]          r_ring [MAX_WINDOW];
    logic [ENT_W-1:0]          r_ring_q;

    // the beat in flight
    logic [PTR_W-1:0]          r_addr;
    logic signed [SAMPLE_W-1:0] r_smp_val;
    logic [1:0]                r_smp_cls;

    logic [LEN_W-1:0]          k;
    logic [PTR_W-1:0]          base_ptr;
    logic [PTR_W-1:0]          rd_addr;

    // update path
    logic                      full;
    logic [1:0]                old_cls;
    logic signed [SAMPLE_W-1:0] old_val;
    logic signed [SAMPLE_W-1:0] new_val;
    logic signed [SUM_W-1:0]   sum_sub;
    logic signed [SUM_W-1:0]   sum_add;
    logic signed [SUM_W-1:0]   n_sum;
    logic [LEN_W-1:0]          n_mis;
    logic [LEN_W-1:0]          n_pinf;
    logic [LEN_W-1:0]          n_ninf;
    logic [LEN_W-1:0]          n_seen;
    logic [CMP_W-1:0]          ptr_inc;
    logic [PTR_W-1:0]          n_ptr;

    // classify path
    rwsm_pkg::t_out_beat       cls_beat;
    rwsm_pkg::t_out_beat       r_pend;
    rwsm_pkg::t_out_beat       r_out;
    logic                      r_out_valid;
    logic                      r_neg;
    logic signed [EXT_W-1:0]   sum_ext;
    logic signed [EXT_W-1:0]   fill_ext;
    logic [SUM_W-1:0]          sum_mag;
    logic [LEN_W-1:0]          divisor;
    logic [SUM_W-1:0]          quo;
    logic signed [EXT_W-1:0]   quo_ext;
    logic signed [EXT_W-1:0]   mean_ext;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign wlen_wr  = i_cfg_we && (i_cfg_index == rwsm_pkg::CFG_WINDOW_LEN);

    // effective window length: zero acts as one, clamp to the ring depth
    always_comb begin
        if (r_wlen == '0) begin
            k = LEN_W'(1);
        end else if (r_wlen > LEN_W'(LEN_CAP)) begin
            k = LEN_W'(LEN_CAP);
        end else begin
            k = r_wlen;
        end
    end

    // ring address for this beat, after an optional series restart
    always_comb begin
        base_ptr = i_in_data.series_start ? '0 : r_ptr;
        rd_addr  = (CMP_W'(base_ptr) >= CMP_W'(k)) ? '0 : base_ptr;
    end

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rwsm_pkg::S_IDLE: begin
                if (in_acc) n_state = rwsm_pkg::S_UPD;
            end
            rwsm_pkg::S_UPD: begin
                n_state = rwsm_pkg::S_CLS;
            end
            rwsm_pkg::S_CLS: begin
                n_state = need_div ? rwsm_pkg::S_DIV : rwsm_pkg::S_OUT;
            end
            rwsm_pkg::S_DIV: begin
                if (div_done) n_state = rwsm_pkg::S_OUT;
            end
            rwsm_pkg::S_OUT: begin
                if (out_free) n_state = rwsm_pkg::S_IDLE;
            end
            default: begin
                n_state = rwsm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        upd_en     = 1'b0;
        cls_en     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            rwsm_pkg::S_IDLE: o_in_ready = 1'b1;
            rwsm_pkg::S_UPD:  upd_en     = 1'b1;
            rwsm_pkg::S_CLS: begin
                cls_en    = 1'b1;
                div_start = need_div;
            end
            rwsm_pkg::S_DIV:  ;
            rwsm_pkg::S_OUT:  out_load   = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rwsm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // config port, written only while idle: a rule for the user, left unchecked
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= LEN_W'(1);
            r_agg  <= 1'b0;
            r_skip <= 1'b0;
            r_fill <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rwsm_pkg::CFG_WINDOW_LEN:     r_wlen <= i_cfg_data[LEN_W-1:0];
                rwsm_pkg::CFG_AGGREGATE_MODE: r_agg  <= i_cfg_data[0];
                rwsm_pkg::CFG_SKIP_MISSING:   r_skip <= i_cfg_data[0];
                rwsm_pkg::CFG_FILL_VALUE:     r_fill <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // ring memory: read at accept, write back during update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ring_q <= r_ring[rd_addr];
        end
        if (upd_en) begin
            r_ring[r_addr] <= {r_smp_cls, new_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr    <= rd_addr;
            r_smp_val <= i_in_data.sample_value;
            r_smp_cls <= i_in_data.sample_class;
        end
    end

    // ------------------------------------------------------------------
    // update: retire the oldest entry once the window is full, add the new one
    // ------------------------------------------------------------------
    always_comb begin
        full    = r_seen >= k;
        old_cls = r_ring_q[SAMPLE_W +: 2];
        old_val = r_ring_q[SAMPLE_W-1:0];
        new_val = (r_smp_cls == rwsm_pkg::SC_FINITE) ? r_smp_val : '0;

        sum_sub = (full && old_cls == rwsm_pkg::SC_FINITE) ? SUM_W'(old_val) : '0;
        sum_add = SUM_W'(new_val);
        n_sum   = r_sum + sum_add - sum_sub;

        n_mis  = r_mis
               + LEN_W'(r_smp_cls == rwsm_pkg::SC_MISSING)
               - LEN_W'(full && old_cls == rwsm_pkg::SC_MISSING);
        n_pinf = r_pinf
               + LEN_W'(r_smp_cls == rwsm_pkg::SC_PINF)
               - LEN_W'(full && old_cls == rwsm_pkg::SC_PINF);
        n_ninf = r_ninf
               + LEN_W'(r_smp_cls == rwsm_pkg::SC_NINF)
               - LEN_W'(full && old_cls == rwsm_pkg::SC_NINF);
        n_seen = full ? r_seen : r_seen + 1'b1;

        ptr_inc = CMP_W'(r_addr) + 1'b1;
        n_ptr   = (ptr_inc >= CMP_W'(k)) ? '0 : ptr_inc[PTR_W-1:0];
    end

    // window registers; a restart or a new window length clears them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || wlen_wr || (in_acc && i_in_data.series_start)) begin
            r_ptr  <= '0;
            r_sum  <= '0;
            r_mis  <= '0;
            r_pinf <= '0;
            r_ninf <= '0;
            r_seen <= '0;
        end else if (upd_en) begin
            r_ptr  <= n_ptr;
            r_sum  <= n_sum;
            r_mis  <= n_mis;
            r_pinf <= n_pinf;
            r_ninf <= n_ninf;
            r_seen <= n_seen;
        end
    end

    // ------------------------------------------------------------------
    // classify the updated window
    // ------------------------------------------------------------------
    assign sum_ext  = EXT_W'(r_sum);
    assign fill_ext = EXT_W'(r_fill);
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign divisor  = k - r_mis;

    always_comb begin
        cls_beat.result_value = '0;
        cls_beat.result_class = rwsm_pkg::RC_FINITE;
        need_div              = 1'b0;
        if (r_seen < k) begin
            cls_beat.result_class = rwsm_pkg::RC_FILL;
            cls_beat.result_value = fill_ext[RES_W-1:0];
        end else if (r_mis == k) begin
            // nothing but missing samples
            if (!r_skip) begin
                cls_beat.result_class = rwsm_pkg::RC_NA;
            end else if (r_agg) begin
                cls_beat.result_class = rwsm_pkg::RC_NAN;
            end
        end else if (r_mis != '0 && !r_skip) begin
            cls_beat.result_class = rwsm_pkg::RC_NA;
        end else if (r_pinf != '0 && r_ninf != '0) begin
            cls_beat.result_class = rwsm_pkg::RC_NAN;
        end else if (r_pinf != '0) begin
            cls_beat.result_class = rwsm_pkg::RC_PINF;
        end else if (r_ninf != '0) begin
            cls_beat.result_class = rwsm_pkg::RC_NINF;
        end else if (r_agg) begin
            need_div = 1'b1;
        end else begin
            cls_beat.result_value = sum_ext[RES_W-1:0];
        end
    end

    rwsm_div #(
        .MAG_W (SUM_W),
        .DIV_W (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // truncate toward zero: divide the magnitude, put the sign back
    assign quo_ext  = EXT_W'(quo);
    assign mean_ext = r_neg ? -quo_ext : quo_ext;

    always_ff @(posedge i_clk) begin
        if (cls_en) begin
            r_pend <= cls_beat;
            r_neg  <= r_sum[SUM_W-1];
        end else if (r_state == rwsm_pkg::S_DIV && div_done) begin
            r_pend.result_value <= mean_ext[RES_W-1:0];
            r_pend.result_class <= rwsm_pkg::RC_FINITE;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/rwsm_chk.sv]
// ----------------------------------------------------------------------------
// rwsm_chk
// port-level checks for the rolling window sum and mean unit
// ----------------------------------------------------------------------------
module rwsm_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input rwsm_pkg::t_out_beat            o_out_data
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    // a stalled result beat stays up and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // one item in flight: no second accept right after one
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input accepted while previous item still in work");

    // special classes carry a zero value
    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.result_class == rwsm_pkg::RC_NA
                     || o_out_data.result_class == rwsm_pkg::RC_NAN
                     || o_out_data.result_class == rwsm_pkg::RC_PINF
                     || o_out_data.result_class == rwsm_pkg::RC_NINF)
        |-> o_out_data.result_value == '0)
        else $error("nonzero value on NA, NaN or infinite result");

    // fill results are a sign-extended 32-bit value
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_class == rwsm_pkg::RC_FILL
        |-> (o_out_data.result_value[rwsm_pkg::RES_W-1:31] == '0)
         || (o_out_data.result_value[rwsm_pkg::RES_W-1:31] == '1))
        else $error("fill value not a sign-extended 32-bit word");

    // no result class code beyond minus infinity
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.result_class <= rwsm_pkg::RC_NINF)
        else $error("result class code out of range");

endmodule

bind rolling_window_sum_mean_unit rwsm_chk u_rwsm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[dv/rolling_window_sum_mean_unit_test.sv]
// ----------------------------------------------------------------------------
// rolling_window_sum_mean_unit_test
// self-checking bench for the rolling window sum and mean unit
// ----------------------------------------------------------------------------
// A short table of hand-picked beats comes first: each sample class at the
// default window of one, window length zero, fill while the window is
// partial, the infinity and NA rules, and the mean of missing-only and mixed
// windows. Random phases follow, each with its own window length, sum or
// mean, missing policy and fill value. One long phase writes a window length
// above the maximum and fills the clamped window with the most negative
// sample, so the sum reaches its lower bound. A shadow model of the window
// predicts every result that the table does not type in, both handshakes
// idle at random, and the output side stalls.
// ----------------------------------------------------------------------------
module rolling_window_sum_mean_unit_test;

    localparam int WIN_MAX     = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_PHASES    = 20;
    localparam int BIG_PHASE   = 8;    // clamped max window, filled with min samples
    localparam int BIG_ITEMS   = 1060;
    localparam int BIG_FILL    = 1030;
    localparam int PHASE_ITEMS = 27;

    typedef struct {
        bit                             is_cfg;
        logic [rwsm_pkg::CFG_IDX_W-1:0] idx;
        logic [rwsm_pkg::CFG_W-1:0]     data;
        rwsm_pkg::t_in_beat             beat;
        bit                             chk;    // expected result typed in below
        rwsm_pkg::t_out_beat            exp;
    } t_stim_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           in_vld;
    logic                           in_rdy;
    rwsm_pkg::t_in_beat             in_dat;
    logic                           out_vld;
    logic                           out_rdy;
    rwsm_pkg::t_out_beat            out_dat;
    logic                           cfg_we;
    logic [rwsm_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [rwsm_pkg::CFG_W-1:0]     cfg_dat;

    // typed expectation that travels with the beat being offered
    bit                  tab_chk;
    rwsm_pkg::t_out_beat tab_exp;

    // shadow copy of the window and the registers
    longint         win_val [WIN_MAX];
    logic [1:0]     win_cls [WIN_MAX];
    int unsigned    win_ptr   = 0;
    longint         win_sum   = 0;
    int unsigned    n_missing = 0;
    int unsigned    n_pinf    = 0;
    int unsigned    n_ninf    = 0;
    int unsigned    n_seen    = 0;
    logic [rwsm_pkg::LEN_W-1:0] len_reg = 1;
    logic           mean_mode = 1'b0;
    logic           skip_na   = 1'b0;
    logic [31:0]    fill_q    = '0;

    rwsm_pkg::t_out_beat window_results_due [$];

    int  n_fail    = 0;
    int  n_checked = 0;
    int  n_beats   = 0;
    int  cycles    = 0;
    int  cls_seen [6];
    bit  calm      = 1'b1;    // no idling on either side
    int  miss_pct  = 0;
    int  inf_pct   = 0;

    rolling_window_sum_mean_unit #(
        .MAX_WINDOW(WIN_MAX)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_vld),
        .o_in_ready (in_rdy),
        .i_in_data  (in_dat),
        .o_out_valid(out_vld),
        .i_out_ready(out_rdy),
        .o_out_data (out_dat),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_idx),
        .i_cfg_data (cfg_dat)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------------
    function automatic void clear_window();
        win_ptr   = 0;
        win_sum   = 0;
        n_missing = 0;
        n_pinf    = 0;
        n_ninf    = 0;
        n_seen    = 0;
    endfunction

    function automatic void apply_cfg_write(logic [rwsm_pkg::CFG_IDX_W-1:0] idx,
                                            logic [rwsm_pkg::CFG_W-1:0] d);
        case (idx)
            rwsm_pkg::CFG_WINDOW_LEN: begin
                len_reg = d[rwsm_pkg::LEN_W-1:0];
                clear_window();
            end
            rwsm_pkg::CFG_AGGREGATE_MODE: mean_mode = d[0];
            rwsm_pkg::CFG_SKIP_MISSING:   skip_na   = d[0];
            rwsm_pkg::CFG_FILL_VALUE:     fill_q    = d;
            default: ;
        endcase
    endfunction

    // push one sample through the window, return the result it gives
    function automatic rwsm_pkg::t_out_beat advance_window(rwsm_pkg::t_in_beat b);
        int unsigned         k;
        int unsigned         p;
        longint              v;
        longint              q;
        rwsm_pkg::t_out_beat r;
        // zero acts as one, anything above the ring size as the ring size
        k = (len_reg == 0) ? 1 : ((len_reg > WIN_MAX) ? WIN_MAX : len_reg);
        v = longint'(b.sample_value);
        if (b.series_start)
            clear_window();
        p = win_ptr;
        if (p >= k)
            p = 0;
        // retire the oldest sample once the window is full
        if (n_seen >= k) begin
            case (win_cls[p])
                rwsm_pkg::SC_FINITE:  win_sum -= win_val[p];
                rwsm_pkg::SC_MISSING: n_missing--;
                rwsm_pkg::SC_PINF:    n_pinf--;
                default:              n_ninf--;
            endcase
        end else begin
            n_seen++;
        end
        win_cls[p] = b.sample_class;
        win_val[p] = (b.sample_class == rwsm_pkg::SC_FINITE) ? v : 0;
        case (b.sample_class)
            rwsm_pkg::SC_FINITE:  win_sum += v;
            rwsm_pkg::SC_MISSING: n_missing++;
            rwsm_pkg::SC_PINF:    n_pinf++;
            default:              n_ninf++;
        endcase
        p++;
        if (p >= k)
            p = 0;
        win_ptr = p;

        r.result_value = '0;
        if (n_seen < k) begin
            r.result_class = rwsm_pkg::RC_FILL;
            r.result_value = {{(rwsm_pkg::RES_W-32){fill_q[31]}}, fill_q};
        end else if (n_missing == k) begin
            r.result_class = !skip_na ? rwsm_pkg::RC_NA
                           : (mean_mode ? rwsm_pkg::RC_NAN : rwsm_pkg::RC_FINITE);
        end else if (n_missing != 0 && !skip_na) begin
            r.result_class = rwsm_pkg::RC_NA;
        end else if (n_pinf != 0 && n_ninf != 0) begin
            r.result_class = rwsm_pkg::RC_NAN;
        end else if (n_pinf != 0) begin
            r.result_class = rwsm_pkg::RC_PINF;
        end else if (n_ninf != 0) begin
            r.result_class = rwsm_pkg::RC_NINF;
        end else begin
            r.result_class = rwsm_pkg::RC_FINITE;
            // signed division truncates toward zero
            q = mean_mode ? (win_sum / longint'(k - n_missing)) : win_sum;
            r.result_value = q[rwsm_pkg::RES_W-1:0];
        end
        return r;
    endfunction

    function automatic bit count_fail();
        n_fail++;
        return (n_fail <= 10);
    endfunction

    // ------------------------------------------------------------------------
    // monitor: checks output beats, follows config writes, predicts on accept
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rwsm_pkg::t_out_beat got;
        rwsm_pkg::t_out_beat want;
        rwsm_pkg::t_out_beat pred;
        if (i_rst_n) begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results still due",
                         cycles, window_results_due.size());
                $display("FAIL rolling_window_sum_mean_unit");
                $finish;
            end else begin
                // output first: a result never leaves in the cycle its beat enters
                if (out_vld && out_rdy) begin
                    got = out_dat;
                    if (got.result_class <= rwsm_pkg::RC_NINF)
                        cls_seen[got.result_class]++;
                    if (window_results_due.size() == 0) begin
                        if (count_fail())
                            $display("unexpected result beat: class %0d value %0d",
                                     got.result_class, got.result_value);
                    end else begin
                        want = window_results_due.pop_front();
                        n_checked++;
                        if (got.result_class !== want.result_class ||
                            got.result_value !== want.result_value) begin
                            if (count_fail())
                                $display({"result %0d mismatch: expected class %0d ",
                                          "value %0d, got class %0d value %0d"},
                                         n_checked, want.result_class,
                                         want.result_value, got.result_class,
                                         got.result_value);
                        end
                    end
                end
                if (cfg_we)
                    apply_cfg_write(cfg_idx, cfg_dat);
                if (in_vld && in_rdy) begin
                    pred = advance_window(in_dat);
                    window_results_due.push_back(tab_chk ? tab_exp : pred);
                    n_beats++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // idle lengths: mostly short, now and then long
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // output side stalls
    initial begin
        int n;
        out_rdy = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_rdy = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_rdy = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks, all entered and left at a falling edge
    // ------------------------------------------------------------------------
    // leaves valid high; the caller either offers the next beat or lowers it
    task automatic send_beat(rwsm_pkg::t_in_beat b, bit chk, rwsm_pkg::t_out_beat exp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_vld = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_dat  = b;
        tab_chk = chk;
        tab_exp = exp;
        in_vld  = 1'b1;
        do @(posedge i_clk); while (!in_rdy);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every due result, then let the block settle
    task automatic drain();
        in_vld = 1'b0;
        while (window_results_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [rwsm_pkg::CFG_IDX_W-1:0] idx,
                             logic [rwsm_pkg::CFG_W-1:0] d);
        cfg_idx = idx;
        cfg_dat = d;
        cfg_we  = 1'b1;
        @(negedge i_clk);
        cfg_we = 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_stim_row beat_row(logic [1:0] cls, logic [31:0] val, bit st = 0,
                                           bit chk = 0,
                                           logic [2:0] ecls = rwsm_pkg::RC_FINITE,
                                           logic signed [rwsm_pkg::RES_W-1:0] ev = '0);
        t_stim_row r;
        r.is_cfg                = 1'b0;
        r.idx                   = '0;
        r.data                  = '0;
        r.beat.sample_value     = val;
        r.beat.sample_class     = cls;
        r.beat.series_start     = st;
        r.chk                   = chk;
        r.exp.result_class      = ecls;
        r.exp.result_value      = ev;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(logic [rwsm_pkg::CFG_IDX_W-1:0] idx,
                                          logic [rwsm_pkg::CFG_W-1:0] d);
        t_stim_row r;
        r      = beat_row(rwsm_pkg::SC_FINITE, '0);
        r.is_cfg = 1'b1;
        r.idx  = idx;
        r.data = d;
        return r;
    endfunction

    function automatic rwsm_pkg::t_in_beat rand_beat();
        rwsm_pkg::t_in_beat b;
        int                 r;
        case ($urandom_range(0, 9))
            0:       b.sample_value = 32'h7FFF_FFFF;
            1:       b.sample_value = 32'h8000_0000;
            2:       b.sample_value = $urandom_range(0, 16) - 8;
            3:       b.sample_value = '0;
            default: b.sample_value = $urandom;
        endcase
        r = $urandom_range(0, 99);
        if (r < miss_pct)
            b.sample_class = rwsm_pkg::SC_MISSING;
        else if (r < miss_pct + inf_pct)
            b.sample_class = $urandom_range(0, 1) ? rwsm_pkg::SC_PINF : rwsm_pkg::SC_NINF;
        else
            b.sample_class = rwsm_pkg::SC_FINITE;
        b.series_start = ($urandom_range(0, 49) == 0);
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_stim_row          dir_tab [$];
        rwsm_pkg::t_in_beat b;
        int                 len;
        int                 items;
        int                 style;

        i_rst_n = 1'b0;
        in_vld  = 1'b0;
        in_dat  = '0;
        cfg_we  = 1'b0;
        cfg_idx = rwsm_pkg::CFG_WINDOW_LEN;
        cfg_dat = '0;
        tab_chk = 1'b0;
        tab_exp = '0;

        // default window of one: every sample is a full window
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, 32'h7FFF_FFFF, 0, 1,
                                   rwsm_pkg::RC_FINITE, 42'sh7FFF_FFFF));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, 32'h8000_0000, 0, 1,
                                   rwsm_pkg::RC_FINITE, -42'sh8000_0000));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_MISSING, 32'h1234_5678, 0, 1,
                                   rwsm_pkg::RC_NA));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_PINF, 32'h0000_0001, 0, 1,
                                   rwsm_pkg::RC_PINF));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_NINF, 32'hFFFF_FFFF, 0, 1,
                                   rwsm_pkg::RC_NINF));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, '0, 1, 1, rwsm_pkg::RC_FINITE));
        // window length zero behaves as one
        dir_tab.push_back(cfg_row(rwsm_pkg::CFG_WINDOW_LEN, '0));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, 32'd5, 0, 1,
                                   rwsm_pkg::RC_FINITE, 42'sd5));
        // window of three, most negative fill
        dir_tab.push_back(cfg_row(rwsm_pkg::CFG_WINDOW_LEN, 32'd3));
        dir_tab.push_back(cfg_row(rwsm_pkg::CFG_FILL_VALUE, 32'h8000_0000));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, 32'h7FFF_FFFF, 0, 1,
                                   rwsm_pkg::RC_FILL, -42'sh8000_0000));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, 32'h7FFF_FFFF, 0, 1,
                                   rwsm_pkg::RC_FILL, -42'sh8000_0000));
        // largest three-sample sum
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, 32'h7FFF_FFFF));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_PINF, '0));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_NINF, '0));       // both infinities
        dir_tab.push_back(beat_row(rwsm_pkg::SC_MISSING, '0));    // missing without skip
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, 32'd1, 1, 1,
                                   rwsm_pkg::RC_FILL, -42'sh8000_0000));
        // skip missing, mean, most positive fill
        dir_tab.push_back(cfg_row(rwsm_pkg::CFG_SKIP_MISSING, 32'd1));
        dir_tab.push_back(cfg_row(rwsm_pkg::CFG_AGGREGATE_MODE, 32'd1));
        dir_tab.push_back(cfg_row(rwsm_pkg::CFG_FILL_VALUE, 32'h7FFF_FFFF));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_MISSING, '0, 1, 1,
                                   rwsm_pkg::RC_FILL, 42'sh7FFF_FFFF));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_MISSING, '0, 0, 1,
                                   rwsm_pkg::RC_FILL, 42'sh7FFF_FFFF));
        // mean of nothing
        dir_tab.push_back(beat_row(rwsm_pkg::SC_MISSING, '0, 0, 1, rwsm_pkg::RC_NAN));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, 32'd7));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, -32'sd8));  // -1/2 truncates to 0
        dir_tab.push_back(beat_row(rwsm_pkg::SC_FINITE, -32'sd9));  // -10/3 truncates to -3
        dir_tab.push_back(beat_row(rwsm_pkg::SC_PINF, '0));         // infinity with skip
        // all missing with skip gives a finite zero sum
        dir_tab.push_back(cfg_row(rwsm_pkg::CFG_AGGREGATE_MODE, '0));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_MISSING, '0, 1));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_MISSING, '0));
        dir_tab.push_back(beat_row(rwsm_pkg::SC_MISSING, '0));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table, normal idling
        calm = 1'b0;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                drain();
                cfg_write(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_beat(dir_tab[i].beat, dir_tab[i].chk, dir_tab[i].exp);
            end
        end

        // random phases
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            items = PHASE_ITEMS;
            style = $urandom_range(0, 3);
            case (style)
                0:       begin miss_pct = 0;  inf_pct = 0;  end
                1:       begin miss_pct = 5;  inf_pct = 3;  end
                2:       begin miss_pct = 30; inf_pct = 10; end
                default: begin miss_pct = 70; inf_pct = 5;  end
            endcase
            calm = ($urandom_range(0, 3) == 0);
            if (ph == BIG_PHASE) begin
                len   = 2047;    // clamps to the ring size
                items = BIG_ITEMS;
                miss_pct = 5;
                inf_pct  = 2;
            end else if (ph == BIG_PHASE + 1) begin
                len   = WIN_MAX; // exact maximum, stays partial
                items = 30;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
                    6, 7, 8:          len = $urandom_range(7, 40);
                    default:          len = $urandom_range(41, 100);
                endcase
            end
            cfg_write(rwsm_pkg::CFG_WINDOW_LEN, len);
            cfg_write(rwsm_pkg::CFG_AGGREGATE_MODE,
                      (ph == BIG_PHASE) ? 0 : $urandom_range(0, 1));
            cfg_write(rwsm_pkg::CFG_SKIP_MISSING, $urandom_range(0, 1));
            cfg_write(rwsm_pkg::CFG_FILL_VALUE, $urandom);

            for (int i = 0; i < items; i++) begin
                if (ph == BIG_PHASE && i < BIG_FILL) begin
                    // every window sample at the most negative value
                    b.sample_value = 32'h8000_0000;
                    b.sample_class = rwsm_pkg::SC_FINITE;
                    b.series_start = 1'b0;
                end else begin
                    b = rand_beat();
                end
                // hold off until the block has caught up
                if ((ph == 2 && i == 25) || $urandom_range(0, 149) == 0)
                    drain();
                send_beat(b, 1'b0, '0);
            end
        end

        drain();
        repeat (60) @(negedge i_clk);

        $display("ran %0d sample beats through %0d window settings, max window clamped",
                 n_beats, N_PHASES + 3);
        $display("results seen: finite %0d, fill %0d, NA %0d, NaN %0d, +inf %0d, -inf %0d",
                 cls_seen[rwsm_pkg::RC_FINITE], cls_seen[rwsm_pkg::RC_FILL],
                 cls_seen[rwsm_pkg::RC_NA], cls_seen[rwsm_pkg::RC_NAN],
                 cls_seen[rwsm_pkg::RC_PINF], cls_seen[rwsm_pkg::RC_NINF]);
        if (n_fail == 0 && window_results_due.size() == 0) begin
            $display("PASS rolling_window_sum_mean_unit");
        end else begin
            $display("%0d failures, %0d results still due", n_fail,
                     window_results_due.size());
            $display("FAIL rolling_window_sum_mean_unit");
        end
        $finish;
    end

endmodule

[rolling_window_sum_mean_unit.f]
rtl/core/rwsm_pkg.sv
rtl/core/rwsm_div.sv
rtl/core/rolling_window_sum_mean_unit.sv
rtl/core/rwsm_chk.sv
dv/rolling_window_sum_mean_unit_test.sv
